>>> src/gdeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gdeg_pkg;

  localparam int unsigned   DZ_W       = 15;
  localparam logic [14:0]   DZ_RESET   = 15'd8000;
  localparam logic [15:0]   POS_STEP   = 16'd32767;
  localparam logic [15:0]   POS_FAR    = 16'd65534;
  localparam int unsigned   Q_DEPTH    = 2;
  localparam int unsigned   Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned   Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0]    DIR_NEG    = 2'b11;
  localparam logic [1:0]    DIR_CTR    = 2'b00;
  localparam logic [1:0]    DIR_POS    = 2'b01;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [1:0] dir_x;
    logic [1:0] dir_y;
    logic [3:0] face;
    logic       move;
    logic [3:0] chg;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } q_rd_t;

  function automatic logic [15:0] dir_to_pos(input logic [1:0] dir);
    logic [15:0] pos;
    unique case (dir)
      DIR_NEG: pos = 16'd0;
      DIR_POS: pos = POS_FAR;
      default: pos = POS_STEP;
    endcase
    return pos;
  endfunction

endpackage
`default_nettype wire

>>> src/gdeg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gdeg_in_if;
  logic               valid;
  logic               ready;
  logic               read_ok;
  logic [15:0]        raw_buttons;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;

  modport source (output valid, read_ok, raw_buttons, stick_x, stick_y, input ready);
  modport sink   (input valid, read_ok, raw_buttons, stick_x, stick_y, output ready);
endinterface

interface gdeg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [1:0]  button_index;
  logic [3:0]  button_mask;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        last_of_run;

  modport source (output valid, event_kind, button_index, button_mask, pos_x, pos_y,
                  last_of_run, input ready);
  modport sink   (input valid, event_kind, button_index, button_mask, pos_x, pos_y,
                  last_of_run, output ready);
endinterface
`default_nettype wire

>>> src/gdeg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gdeg_front
  import gdeg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [DZ_W-1:0] deadzone,
  gdeg_in_if.sink              in_ch,
  input  wire logic            q_full,
  output q_wr_t                q_wr
);

  logic [1:0]         prev_x_r, prev_y_r;
  logic [3:0]         prev_face_r;
  logic [1:0]         dx, dy;
  logic [3:0]         face;
  logic signed [16:0] sx_w, sy_w, dz_w;
  logic signed [16:0] sx_sum, sx_dif, sy_sum, sy_dif;
  logic               accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign sx_w   = {in_ch.stick_x[15], in_ch.stick_x};
  assign sy_w   = {in_ch.stick_y[15], in_ch.stick_y};
  assign dz_w   = {2'b00, deadzone};
  assign sx_sum = sx_w + dz_w;
  assign sx_dif = dz_w - sx_w;
  assign sy_sum = sy_w + dz_w;
  assign sy_dif = dz_w - sy_w;
  assign face   = in_ch.raw_buttons[15:12];

  always_comb begin
    priority if (in_ch.raw_buttons[3]) begin
      dx = DIR_POS;
    end else if (in_ch.raw_buttons[2]) begin
      dx = DIR_NEG;
    end else if (sx_sum[16]) begin
      dx = DIR_NEG;
    end else if (sx_dif[16]) begin
      dx = DIR_POS;
    end else begin
      dx = DIR_CTR;
    end
  end

  always_comb begin
    priority if (in_ch.raw_buttons[1]) begin
      dy = DIR_POS;
    end else if (in_ch.raw_buttons[0]) begin
      dy = DIR_NEG;
    end else if (sy_sum[16]) begin
      dy = DIR_POS;
    end else if (sy_dif[16]) begin
      dy = DIR_NEG;
    end else begin
      dy = DIR_CTR;
    end
  end

  always_comb begin
    q_wr.job.dir_x = dx;
    q_wr.job.dir_y = dy;
    q_wr.job.face  = face;
    q_wr.job.move  = (dx != prev_x_r) || (dy != prev_y_r);
    q_wr.job.chg   = face ^ prev_face_r;
    q_wr.push      = accept && in_ch.read_ok && (q_wr.job.move || (|q_wr.job.chg));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= DIR_CTR;
      prev_y_r    <= DIR_CTR;
      prev_face_r <= 4'd0;
    end else if (accept && in_ch.read_ok) begin
      prev_x_r    <= dx;
      prev_y_r    <= dy;
      prev_face_r <= face;
    end
  end

endmodule
`default_nettype wire

>>> src/gdeg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gdeg_queue
  import gdeg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  input  wire logic  pop,
  output q_rd_t      q_rd
);

  job_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_pop;

  assign q_full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_rd.avail = (cnt_r != '0);
  assign q_rd.job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && q_rd.avail;

  always_ff @(posedge clk) begin
    if (q_wr.push && !q_full) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push && !q_full) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({q_wr.push && !q_full, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/gdeg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gdeg_back
  import gdeg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_rd_t q_rd,
  output logic       pop,
  gdeg_out_if.source out_ch
);

  logic        cur_valid_r, cur_valid_nxt;
  job_t        cur_r, cur_nxt;
  logic        out_valid_r;
  logic [1:0]  kind_r, idx_r;
  logic [3:0]  mask_r;
  logic [15:0] pos_x_r, pos_y_r;
  logic        last_r;

  logic        emit, ev_last;
  logic [1:0]  ev_idx;
  event_kind_t ev_kind;
  logic [3:0]  chg_left;

  assign emit = cur_valid_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    priority if (cur_r.chg[0]) begin
      ev_idx = 2'd0;
    end else if (cur_r.chg[1]) begin
      ev_idx = 2'd1;
    end else if (cur_r.chg[2]) begin
      ev_idx = 2'd2;
    end else begin
      ev_idx = 2'd3;
    end
  end

  always_comb begin
    chg_left = cur_r.chg;
    if (cur_r.move) begin
      ev_kind = EV_MOVE;
    end else begin
      ev_kind          = cur_r.face[ev_idx] ? EV_PRESS : EV_RELEASE;
      chg_left[ev_idx] = 1'b0;
    end
    ev_last = (chg_left == 4'd0);
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    pop           = 1'b0;
    if (emit) begin
      cur_nxt.move = 1'b0;
      cur_nxt.chg  = chg_left;
    end
    if (!cur_valid_r || (emit && ev_last)) begin
      pop           = q_rd.avail;
      cur_valid_nxt = q_rd.avail;
      cur_nxt       = q_rd.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      kind_r  <= ev_kind;
      idx_r   <= cur_r.move ? 2'd0 : ev_idx;
      mask_r  <= cur_r.face;
      pos_x_r <= dir_to_pos(cur_r.dir_x);
      pos_y_r <= dir_to_pos(cur_r.dir_y);
      last_r  <= ev_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = kind_r;
  assign out_ch.button_index = idx_r;
  assign out_ch.button_mask  = mask_r;
  assign out_ch.pos_x        = pos_x_r;
  assign out_ch.pos_y        = pos_y_r;
  assign out_ch.last_of_run  = last_r;

`ifndef SYNTHESIS
  a_job_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.move || (cur_r.chg != 4'd0)))
    else $error("held job has no pending event");

  a_press_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == EV_PRESS) |-> mask_r[idx_r])
    else $error("press event on a released button");

  a_release_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == EV_RELEASE) |-> !mask_r[idx_r])
    else $error("release event on a pressed button");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!cur_valid_r || (emit && ev_last)))
    else $error("queue popped while a job is still running");
`endif

endmodule
`default_nettype wire

>>> src/gamepad_direction_event_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Gamepad direction event generator. Each valid sample is reduced to a
// direction per axis and a face button mask; a move event if a direction
// changed, then one press or release event per changed face button (A, B,
// X, Y) follow. Samples are taken one per cycle while the two-entry job
// queue has room; a failed read or an unchanged sample is absorbed in that
// cycle and gives nothing. The event stage issues one event per cycle while
// the output is not stalled; a sample with n events (1 to 5) holds it until
// all n are issued. Deadzone writes apply to samples taken afterwards.
module gamepad_direction_event_generator
  import gdeg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [DZ_W-1:0] cfg_wdata,
  gdeg_in_if.sink              in_ch,
  gdeg_out_if.source           out_ch
);

  logic [DZ_W-1:0] deadzone_r;
  q_wr_t           q_wr;
  q_rd_t           q_rd;
  logic            q_full;
  logic            pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= DZ_RESET;
    end else if (cfg_we) begin
      deadzone_r <= cfg_wdata;
    end
  end

  gdeg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .deadzone (deadzone_r),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  gdeg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  gdeg_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
